// ----- rtl/priority_channel_allocator_top_defines.svh -----
// Assertion macros for the allocator checker
`ifndef PRIORITY_CHANNEL_ALLOCATOR_TOP_DEFINES_SVH
`define PRIORITY_CHANNEL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// next-cycle implication, disabled in reset
`define PCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

// ----- rtl/pca_pkg.sv -----
// Types, codes and helpers for the priority channel allocator
package pca_pkg;

	localparam int TIME_W            = 32;
	localparam int CNT_W             = 32;
	localparam int CHAN_ID_W         = 4;
	localparam int SIM_END_W         = 16;
	localparam int CHANNELS_DEF      = 10;
	localparam int NEW_DEPTH_DEF     = 5;
	localparam int HANDOFF_DEPTH_DEF = 7;

	localparam logic [SIM_END_W-1:0] SIM_END_RESET = 16'd1000;

	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CHAN_ID_W-1:0] chan_id_t;
	typedef logic [1:0]           class_t;

	localparam class_t CLS_PRIMARY = 2'd0;
	localparam class_t CLS_RT      = 2'd1;
	localparam class_t CLS_NRT     = 2'd2;
	localparam class_t CLS_NRT_ALT = 2'd3;

	localparam logic SRC_HANDOFF = 1'b0;
	localparam logic SRC_NEW     = 1'b1;

	typedef enum logic [2:0] {
		ACT_GRANT      = 3'd0,
		ACT_HANDOFF    = 3'd1,
		ACT_LOST       = 3'd2,
		ACT_PREEMPT_RT = 3'd3,
		ACT_QUEUED     = 3'd4,
		ACT_BLOCKED    = 3'd5,
		ACT_PRI_LOST   = 3'd6
	} action_t;

	typedef struct packed {
		logic     en;
		chan_id_t idx;
		time_t    busy;
		class_t   owner;
	} chan_upd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		action_t  action;
		chan_id_t grant;
		logic     dvalid;
		chan_id_t dchan;
		logic     dsrc;
		cnt_t     blocked;
		cnt_t     preempted;
	} result_t;

	function automatic time_t sat_add(input time_t a, input time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

endpackage

// ----- rtl/pca_fifo.sv -----
// Circular FIFO with registered head read, for queued service times
module pca_fifo #(
	parameter int DEPTH = pca_pkg::NEW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pca_pkg::time_t     push_data,
	input  logic               pop,
	output pca_pkg::fifo_stat_t stat,
	output pca_pkg::time_t     head_data
);
	import pca_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_F = $clog2(DEPTH + 1);

	time_t              mem [DEPTH];
	time_t              rd_q;
	logic [PTR_W-1:0]   head_q, tail_q, head_d;
	logic [CNT_W_F-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_d = pop ? ptr_inc(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			if (push)
				tail_q <= ptr_inc(tail_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// head register tracks mem[head]; bypass a write landing on the new head
	always_ff @(posedge clk) begin
		if (push)
			mem[tail_q] <= push_data;
		rd_q <= (push && tail_q == head_d) ? push_data : mem[head_d];
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W_F'(DEPTH));
	assign head_data  = rd_q;

endmodule

// ----- rtl/pca_chan_bank.sv -----
// Per-channel busy-until and owner class registers with two update ports
module pca_chan_bank #(
	parameter int CHANNELS = pca_pkg::CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pca_pkg::chan_upd_t                 upd_a,
	input  pca_pkg::chan_upd_t                 upd_b,
	output logic [CHANNELS-1:0][pca_pkg::TIME_W-1:0] busy,
	output logic [CHANNELS-1:0][1:0]           owner
);
	import pca_pkg::*;

	logic [CHANNELS-1:0][TIME_W-1:0] busy_q;
	logic [CHANNELS-1:0][1:0]        owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			owner_q <= '0;
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (upd_a.en && upd_a.idx == CHAN_ID_W'(i)) begin
					busy_q[i]  <= upd_a.busy;
					owner_q[i] <= upd_a.owner;
				end else if (upd_b.en && upd_b.idx == CHAN_ID_W'(i)) begin
					busy_q[i]  <= upd_b.busy;
					owner_q[i] <= upd_b.owner;
				end
			end
		end
	end

	assign busy  = busy_q;
	assign owner = owner_q;

endmodule

// ----- rtl/pca_decide.sv -----
// Allocation decision for one arrival: grant, preempt, queue, block, dispatch
module pca_decide #(
	parameter int CHANNELS = pca_pkg::CHANNELS_DEF
) (
	input  pca_pkg::time_t                      arrival_time,
	input  pca_pkg::class_t                     user_class,
	input  pca_pkg::time_t                      service_time,
	input  logic [CHANNELS-1:0][pca_pkg::TIME_W-1:0] busy,
	input  logic [CHANNELS-1:0][1:0]            owner,
	input  logic [pca_pkg::SIM_END_W-1:0]       sim_end,
	input  pca_pkg::fifo_stat_t                 h_stat,
	input  pca_pkg::time_t                      h_head,
	input  pca_pkg::fifo_stat_t                 n_stat,
	input  pca_pkg::time_t                      n_head,
	input  pca_pkg::cnt_t                       blocked,
	input  pca_pkg::cnt_t                       preempted,
	output pca_pkg::chan_upd_t                  upd_a,
	output pca_pkg::chan_upd_t                  upd_b,
	output logic                                h_push,
	output pca_pkg::time_t                      h_push_data,
	output logic                                h_pop,
	output logic                                n_push,
	output logic                                n_pop,
	output pca_pkg::result_t                    res
);
	import pca_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CHANNELS-1:0] free_v, free2_v, nrt_v, rt_v;
	logic [CH_W-1:0]     f1, f2, f_disp, c_nrt, c_rt, c_pre;
	class_t              cls;
	time_t               end_fx, pre_busy, dur;
	logic                do_disp, blk_inc, pre_inc;

	function automatic logic [CH_W-1:0] first_idx(input logic [CHANNELS-1:0] v);
		logic [CH_W-1:0] idx;
		idx = '0;
		for (int i = CHANNELS - 1; i >= 0; i--)
			if (v[i])
				idx = CH_W'(i);
		return idx;
	endfunction

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			free_v[i] = (busy[i] <= arrival_time);
			nrt_v[i]  = (owner[i] == CLS_NRT);
			rt_v[i]   = (owner[i] == CLS_RT);
		end
		f1 = first_idx(free_v);
		for (int i = 0; i < CHANNELS; i++)
			free2_v[i] = free_v[i] && (CH_W'(i) != f1);
		f2     = first_idx(free2_v);
		c_nrt  = first_idx(nrt_v);
		c_rt   = first_idx(rt_v);
		c_pre  = (|nrt_v) ? c_nrt : c_rt;
		pre_busy = busy[c_pre];
	end

	assign cls    = (user_class == CLS_NRT_ALT) ? CLS_NRT : user_class;
	assign end_fx = {sim_end, {(TIME_W - SIM_END_W){1'b0}}};
	// a zero service time leaves the granted channel free for the dispatch
	assign f_disp = (service_time == '0) ? f1 : f2;

	always_comb begin
		upd_a       = '0;
		upd_b       = '0;
		h_push      = 1'b0;
		h_push_data = pre_busy - arrival_time;
		h_pop       = 1'b0;
		n_push      = 1'b0;
		n_pop       = 1'b0;
		blk_inc     = 1'b0;
		pre_inc     = 1'b0;
		do_disp     = 1'b0;
		dur         = h_head;
		res         = '0;
		res.action  = ACT_GRANT;

		if (|free_v) begin
			upd_a.en    = 1'b1;
			upd_a.idx   = CHAN_ID_W'(f1);
			upd_a.busy  = sat_add(arrival_time, service_time);
			upd_a.owner = cls;
			res.grant   = CHAN_ID_W'(f1);
			do_disp = (|free2_v) && (arrival_time < end_fx) && !(h_stat.empty && n_stat.empty);
		end else if (cls == CLS_PRIMARY) begin
			if ((|nrt_v) || (|rt_v)) begin
				upd_a.en    = 1'b1;
				upd_a.idx   = CHAN_ID_W'(c_pre);
				upd_a.busy  = sat_add(arrival_time, service_time);
				upd_a.owner = CLS_PRIMARY;
				res.grant   = CHAN_ID_W'(c_pre);
				if (|nrt_v) begin
					if (pre_busy <= end_fx && !h_stat.full) begin
						h_push     = 1'b1;
						res.action = ACT_HANDOFF;
					end else begin
						pre_inc    = 1'b1;
						res.action = ACT_LOST;
					end
				end else begin
					pre_inc    = 1'b1;
					res.action = ACT_PREEMPT_RT;
				end
			end else begin
				res.action = ACT_PRI_LOST;
			end
		end else if (cls == CLS_RT) begin
			blk_inc    = 1'b1;
			res.action = ACT_BLOCKED;
		end else if (!n_stat.full) begin
			n_push     = 1'b1;
			res.action = ACT_QUEUED;
		end else begin
			blk_inc    = 1'b1;
			res.action = ACT_BLOCKED;
		end

		if (do_disp) begin
			if (!h_stat.empty) begin
				h_pop    = 1'b1;
				res.dsrc = SRC_HANDOFF;
			end else begin
				n_pop    = 1'b1;
				dur      = n_head;
				res.dsrc = SRC_NEW;
			end
			if (service_time == '0)
				upd_a.en = 1'b0;
			upd_b.en    = 1'b1;
			upd_b.idx   = CHAN_ID_W'(f_disp);
			upd_b.busy  = sat_add(arrival_time, dur);
			upd_b.owner = CLS_NRT;
			res.dvalid  = 1'b1;
			res.dchan   = CHAN_ID_W'(f_disp);
		end

		res.blocked   = blk_inc ? sat_inc(blocked) : blocked;
		res.preempted = pre_inc ? sat_inc(preempted) : preempted;
	end

endmodule

// ----- rtl/priority_channel_allocator_top.sv -----
// Priority channel allocator: top level with input register, decision and result register
//
// One arrival is accepted per cycle while in_stall is low; it is captured in the input
// register, then its result is presented from the result register. The channel
// table and both FIFOs are updated as an item moves from the input register
// to the result register, so the following item already sees that state;
// this combinational update loop through the channel compare, the priority encoders
// and the saturating add sets the rate of one item per cycle while out_stall is low.
// There is no clearing pass: the block accepts items right after reset.
// Write sim_end_time through cfg_we/cfg_wdata only while the block is idle (not enforced).
module priority_channel_allocator_top #(
	parameter int CHANNELS      = pca_pkg::CHANNELS_DEF,
	parameter int NEW_DEPTH     = pca_pkg::NEW_DEPTH_DEF,
	parameter int HANDOFF_DEPTH = pca_pkg::HANDOFF_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pca_pkg::SIM_END_W-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pca_pkg::time_t                  arrival_time,
	input  pca_pkg::class_t                 user_class,
	input  pca_pkg::time_t                  service_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      action,
	output pca_pkg::chan_id_t               granted_channel,
	output logic                            dispatch_valid,
	output pca_pkg::chan_id_t               dispatch_channel,
	output logic                            dispatch_source,
	output pca_pkg::cnt_t                   blocked_total,
	output pca_pkg::cnt_t                   preempted_total
);
	import pca_pkg::*;

	logic                            s1_valid, s2_valid, load1, adv2;
	time_t                           arrival_time_s1, service_time_s1;
	class_t                          user_class_s1;
	result_t                         res_d, res_s2;
	logic [SIM_END_W-1:0]            sim_end_q;
	cnt_t                            blocked_q, preempted_q;
	logic [CHANNELS-1:0][TIME_W-1:0] busy;
	logic [CHANNELS-1:0][1:0]        owner;
	chan_upd_t                       upd_a_d, upd_b_d, upd_a, upd_b;
	fifo_stat_t                      h_stat, n_stat;
	time_t                           h_head, n_head, h_push_data;
	logic                            h_push_d, h_pop_d, n_push_d, n_pop_d;

	assign load1    = in_valid && !in_stall;
	assign adv2     = s1_valid && (!s2_valid || !out_stall);
	assign in_stall = s1_valid && !adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			sim_end_q   <= SIM_END_RESET;
			blocked_q   <= '0;
			preempted_q <= '0;
		end else begin
			if (load1)
				s1_valid <= 1'b1;
			else if (adv2)
				s1_valid <= 1'b0;
			if (adv2)
				s2_valid <= 1'b1;
			else if (!out_stall)
				s2_valid <= 1'b0;
			if (cfg_we)
				sim_end_q <= cfg_wdata;
			if (adv2) begin
				blocked_q   <= res_d.blocked;
				preempted_q <= res_d.preempted;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			arrival_time_s1 <= arrival_time;
			user_class_s1   <= user_class;
			service_time_s1 <= service_time;
		end
		if (adv2)
			res_s2 <= res_d;
	end

	pca_decide #(
		.CHANNELS(CHANNELS)
	) u_decide (
		.arrival_time (arrival_time_s1),
		.user_class   (user_class_s1),
		.service_time (service_time_s1),
		.busy         (busy),
		.owner        (owner),
		.sim_end      (sim_end_q),
		.h_stat       (h_stat),
		.h_head       (h_head),
		.n_stat       (n_stat),
		.n_head       (n_head),
		.blocked      (blocked_q),
		.preempted    (preempted_q),
		.upd_a        (upd_a_d),
		.upd_b        (upd_b_d),
		.h_push       (h_push_d),
		.h_push_data  (h_push_data),
		.h_pop        (h_pop_d),
		.n_push       (n_push_d),
		.n_pop        (n_pop_d),
		.res          (res_d)
	);

	always_comb begin
		upd_a    = upd_a_d;
		upd_b    = upd_b_d;
		upd_a.en = upd_a_d.en && adv2;
		upd_b.en = upd_b_d.en && adv2;
	end

	pca_chan_bank #(
		.CHANNELS(CHANNELS)
	) u_chan (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_a  (upd_a),
		.upd_b  (upd_b),
		.busy   (busy),
		.owner  (owner)
	);

	pca_fifo #(
		.DEPTH(HANDOFF_DEPTH)
	) u_handoff (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (h_push_d && adv2),
		.push_data (h_push_data),
		.pop       (h_pop_d && adv2),
		.stat      (h_stat),
		.head_data (h_head)
	);

	pca_fifo #(
		.DEPTH(NEW_DEPTH)
	) u_new (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (n_push_d && adv2),
		.push_data (service_time_s1),
		.pop       (n_pop_d && adv2),
		.stat      (n_stat),
		.head_data (n_head)
	);

	assign out_valid        = s2_valid;
	assign action           = res_s2.action;
	assign granted_channel  = res_s2.grant;
	assign dispatch_valid   = res_s2.dvalid;
	assign dispatch_channel = res_s2.dchan;
	assign dispatch_source  = res_s2.dsrc;
	assign blocked_total    = res_s2.blocked;
	assign preempted_total  = res_s2.preempted;

endmodule

// ----- rtl/pca_checker.sv -----
// Port-level checker for the allocator, bound to the top level
`include "priority_channel_allocator_top_defines.svh"

module pca_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    action,
	input pca_pkg::chan_id_t             granted_channel,
	input logic                          dispatch_valid,
	input pca_pkg::chan_id_t             dispatch_channel,
	input logic                          dispatch_source,
	input pca_pkg::cnt_t                 blocked_total,
	input pca_pkg::cnt_t                 preempted_total
);
	import pca_pkg::*;

	`PCA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(action) && $stable(granted_channel) && $stable(blocked_total))

	`PCA_ASSERT_IMP(a_no_grant, clk, arst_n, out_valid && (action == ACT_QUEUED || action == ACT_BLOCKED || action == ACT_PRI_LOST), granted_channel == '0 && !dispatch_valid)

	// a dispatch is only made alongside a grant to a free channel
	`PCA_ASSERT_IMP(a_disp_grant, clk, arst_n, out_valid && dispatch_valid, action == ACT_GRANT)

	`PCA_ASSERT_IMP(a_disp_idle, clk, arst_n, out_valid && !dispatch_valid, dispatch_channel == '0 && dispatch_source == SRC_HANDOFF)

endmodule

bind priority_channel_allocator_top pca_checker u_pca_checker (.*);
